// ----- rtl/pal_pkg.sv -----
// Shared types and constants for the positional array list.
// Depends on nothing; used by pal_cell and positional_array_list.
package pal_pkg;

  localparam int DATA_W      = 32;
  localparam int POS_W       = 5;
  localparam int FUNC_W      = 3;
  localparam int ST_W        = 3;
  localparam int DEPTH_DEF   = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_RM_LAST = 3'd2,
    FN_RM_AT  = 3'd3,
    FN_FIND   = 3'd4,
    FN_READ   = 3'd5,
    FN_CLEAR  = 3'd6
  } func_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // per-cell command broadcast along the row
  typedef enum logic [2:0] {
    CC_HOLD   = 3'd0,
    CC_WRITE  = 3'd1,
    CC_INSERT = 3'd2,
    CC_REMOVE = 3'd3,
    CC_PROBE  = 3'd4,
    CC_FIND   = 3'd5,
    CC_SHIFT  = 3'd6
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      sel;    // this cell is the target index
    logic      upper;  // this cell lies above the target index
    logic      occ;    // this cell holds a live entry
  } cell_ctl_t;

endpackage

// ----- rtl/pal_cell.sv -----
// One storage cell of the list row: entry, probe and match registers.
// Depends on pal_pkg.
module pal_cell import pal_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] val,
  input  logic [DATA_W-1:0] entry_lo,  // entry of the cell below
  input  logic [DATA_W-1:0] entry_hi,  // entry of the cell above
  input  logic [DATA_W-1:0] probe_hi,
  input  logic              match_hi,
  output logic [DATA_W-1:0] entry,
  output logic [DATA_W-1:0] probe,
  output logic              match
);

  logic [DATA_W-1:0] entry_r, entry_nxt;
  logic [DATA_W-1:0] probe_r, probe_nxt;
  logic              match_r, match_nxt;

  always_comb begin
    entry_nxt = entry_r;
    probe_nxt = probe_r;
    match_nxt = match_r;
    case (ctl.cmd)
      CC_WRITE: begin
        if (ctl.sel) entry_nxt = val;
      end
      CC_INSERT: begin
        if (ctl.sel) entry_nxt = val;
        else if (ctl.upper) entry_nxt = entry_lo;
      end
      CC_REMOVE: begin
        if (ctl.sel || ctl.upper) entry_nxt = entry_hi;
        probe_nxt = entry_r;
        match_nxt = ctl.sel;
      end
      CC_PROBE: begin
        probe_nxt = entry_r;
        match_nxt = ctl.sel;
      end
      CC_FIND: begin
        match_nxt = ctl.occ && (entry_r == val);
      end
      CC_SHIFT: begin
        probe_nxt = probe_hi;
        match_nxt = match_hi;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    probe_r <= probe_nxt;
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign entry = entry_r;
  assign probe = probe_r;
  assign match = match_r;

endmodule

// ----- rtl/positional_array_list.sv -----
// Top level of the positional array list: control sequencer and a row of
// pal_cell storage cells. Depends on pal_pkg and pal_cell.
//
//  channel | dir | handshake            | tdata fields (lsb first)
//  --------+-----+----------------------+---------------------------------------
//  in_     | in  | in_tvalid/in_tready  | func[2:0] value[34:3] position[39:35]
//  out_    | out | out_tvalid/out_tready| status[2:0] data_out[34:3]
//          |     |                      | found_position[39:35] count[44:40]
//          |     |                      | is_empty[45] is_full[46]
//
// Append, insert, clear, error cases and unused codes finish in the accept
// cycle: the result is registered into the output register at its end.
// Remove and read load a probe value and match flag into every cell, find
// only a match flag; the flags then shift one cell a cycle toward cell 0.
// Remove/read end when the flag reaches cell 0; find also at the last entry.
// Reset clears the count; entry contents stay undefined until written.
// A new item is taken only when the output register is empty or is read in
// that same cycle; a finished scan holds in place until the output register
// is free.
module positional_array_list import pal_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // func, value, position
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status, data_out, found_position,
                                             // count, is_empty, is_full, pad
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int KW   = IW + 1;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  // item fields
  func_t             in_func;
  logic [DATA_W-1:0] in_value;
  logic [POS_W-1:0]  in_pos;
  assign in_func  = func_t'(in_tdata[FUNC_W-1:0]);
  assign in_value = in_tdata[FUNC_W +: DATA_W];
  assign in_pos   = in_tdata[FUNC_W+DATA_W +: POS_W];

  state_t            state_r, state_nxt;
  logic              find_r, find_nxt;   // scan is a key search
  logic [IW-1:0]     k_r, k_nxt;         // scan step
  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [POS_W-1:0]  out_found_r, out_found_nxt;

  // row wiring
  cell_cmd_t         cmd;
  logic [IW-1:0]     tgt;
  logic [DATA_W-1:0] entry_w [DEPTH];
  logic [DATA_W-1:0] probe_w [DEPTH];
  logic [DEPTH-1:0]  match_w;

  logic              in_fire, can_out;
  logic [CMPW-1:0]   pos_e, cnt_e;
  logic              full, empty, bad_ins, bad_pos;
  logic [KW-1:0]     k_plus1;

  assign can_out   = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && can_out;
  assign in_fire   = in_tvalid && in_tready;

  assign pos_e   = CMPW'(in_pos);
  assign cnt_e   = CMPW'(count_r);
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign bad_ins = (in_pos == '0) || (pos_e > cnt_e + CMPW'(1));
  assign bad_pos = (in_pos == '0) || (pos_e > cnt_e);
  assign k_plus1 = {1'b0, k_r} + KW'(1);

  always_comb begin
    state_nxt      = state_r;
    find_nxt       = find_r;
    k_nxt          = k_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_found_nxt  = out_found_r;
    cmd            = CC_HOLD;
    tgt            = IW'(pos_e - CMPW'(1));

    if (state_r == S_IDLE) begin
      if (in_fire) begin
        // default: result right away
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_data_nxt   = '0;
        out_found_nxt  = '0;
        find_nxt       = 1'b0;
        k_nxt          = '0;
        case (in_func)
          FN_APPEND: begin
            if (full) begin
              out_status_nxt = ST_FULL;
            end else begin
              tgt       = IW'(cnt_e);
              cmd       = CC_WRITE;
              count_nxt = count_r + CW'(1);
            end
          end
          FN_INSERT: begin
            if (full) begin
              out_status_nxt = ST_FULL;
            end else if (bad_ins) begin
              out_status_nxt = ST_BADPOS;
            end else begin
              cmd       = CC_INSERT;
              count_nxt = count_r + CW'(1);
            end
          end
          FN_RM_LAST: begin
            if (empty) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              tgt           = IW'(cnt_e - CMPW'(1));
              cmd           = CC_PROBE;
              count_nxt     = count_r - CW'(1);
              out_valid_nxt = out_valid_r && !out_tready;
              state_nxt     = S_SCAN;
            end
          end
          FN_RM_AT: begin
            if (empty) begin
              out_status_nxt = ST_EMPTY;
            end else if (bad_pos) begin
              out_status_nxt = ST_BADPOS;
            end else begin
              cmd           = CC_REMOVE;
              count_nxt     = count_r - CW'(1);
              out_valid_nxt = out_valid_r && !out_tready;
              state_nxt     = S_SCAN;
            end
          end
          FN_FIND: begin
            if (empty) begin
              out_status_nxt = ST_NOTFOUND;
            end else begin
              cmd           = CC_FIND;
              find_nxt      = 1'b1;
              out_valid_nxt = out_valid_r && !out_tready;
              state_nxt     = S_SCAN;
            end
          end
          FN_READ: begin
            if (bad_pos) begin
              out_status_nxt = ST_BADPOS;
            end else begin
              cmd           = CC_PROBE;
              out_valid_nxt = out_valid_r && !out_tready;
              state_nxt     = S_SCAN;
            end
          end
          FN_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
    end else begin
      // scan: done when the flagged cell has reached cell 0 or the key search ran out, else shift
      if (match_w[0]) begin
        if (can_out) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = find_r ? '0 : probe_w[0];
          out_found_nxt  = find_r ? POS_W'(k_plus1) : '0;
          state_nxt      = S_IDLE;
        end
      end else if (find_r && (k_r == IW'(cnt_e - CMPW'(1)))) begin
        if (can_out) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOTFOUND;
          out_data_nxt   = '0;
          out_found_nxt  = '0;
          state_nxt      = S_IDLE;
        end
      end else begin
        cmd   = CC_SHIFT;
        k_nxt = IW'(k_plus1);
      end
    end
  end

  always_ff @(posedge clk) begin
    find_r       <= find_nxt;
    k_r          <= k_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_found_r  <= out_found_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // row of cells, cell 0 holds position 1
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctl_t         ctl;
      logic [DATA_W-1:0] lo, hi, phi;
      logic              mhi;

      assign ctl.cmd   = cmd;
      assign ctl.sel   = (tgt == IW'(i));
      assign ctl.upper = (tgt < IW'(i));
      assign ctl.occ   = (CW'(i) < count_r);

      if (i > 0) begin : g_lo
        assign lo = entry_w[i-1];
      end else begin : g_lo0
        assign lo = '0;
      end
      if (i < DEPTH - 1) begin : g_hi
        assign hi  = entry_w[i+1];
        assign phi = probe_w[i+1];
        assign mhi = match_w[i+1];
      end else begin : g_hi0
        assign hi  = '0;
        assign phi = '0;
        assign mhi = 1'b0;
      end

      pal_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .val      (in_value),
        .entry_lo (lo),
        .entry_hi (hi),
        .probe_hi (phi),
        .match_hi (mhi),
        .entry    (entry_w[i]),
        .probe    (probe_w[i]),
        .match    (match_w[i])
      );
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0,
                       (count_r == CW'(DEPTH)),
                       (count_r == '0),
                       POS_W'(count_r),
                       out_found_r,
                       out_data_r,
                       out_status_r};

`ifndef SYNTH
  // count never runs past the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count above depth");

  // a position scan carries exactly one flagged cell at most
  a_probe_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !find_r) |-> $onehot0(match_w))
    else $error("more than one probe flag");

  // an accepted append into a list with room grows it by one
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func == FN_APPEND && !full) |=> count_r == $past(count_r) + CW'(1))
    else $error("append did not grow count");
`endif

endmodule
